// ===== design/mcspg_pkg.sv =====
// Shared types, field widths and codes for the multi-channel servo pulse generator.
// Used by mcspg_tick, the core and its testbench; depends on nothing.
package mcspg_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam int WIDTH_W    = 16;
    localparam int PIN_W      = 9;
    localparam int CH_FIELD_W = 3;
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int LEVELS_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;

    localparam logic [WIDTH_W-1:0] DEFAULT_WIDTH = 16'd1500;
    localparam logic [WIDTH_W-1:0] COUNT_MAX     = 16'hFFFF;

    localparam logic [WIDTH_W-1:0] FRAME_LEN_RST = 16'd20000;
    localparam logic [WIDTH_W-1:0] MIN_PULSE_RST = 16'd500;
    localparam logic [WIDTH_W-1:0] MAX_PULSE_RST = 16'd2500;
    localparam logic [WIDTH_W-1:0] HOLD_RST      = 16'd50;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd3;

    // item modes
    localparam logic [MODE_W-1:0] MODE_TICK      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET_WIDTH = 3'd1;
    localparam logic [MODE_W-1:0] MODE_START     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP_CH   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP_PIN  = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLAMPED       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CHANNEL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PIN_IN_USE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_FREE       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_RUNNING   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_PIN_NOT_FOUND = 3'd6;

    typedef struct packed {
        logic [WIDTH_W-1:0] frame_len;
        logic [WIDTH_W-1:0] hold_periods;
    } tick_cfg_t;

    // one state memory entry per channel
    typedef struct packed {
        logic [PIN_W-1:0]   pin;
        logic [WIDTH_W-1:0] req_width;
        logic [WIDTH_W-1:0] lat_width;
        logic [WIDTH_W-1:0] phase;
        logic [WIDTH_W-1:0] unchanged;
        logic               idle;
    } chan_entry_t;

    localparam int ENTRY_W = $bits(chan_entry_t);

    localparam chan_entry_t ENTRY_RESET = '{
        pin:       '0,
        req_width: DEFAULT_WIDTH,
        lat_width: '0,
        phase:     '0,
        unchanged: '0,
        idle:      1'b0
    };

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SWEEP,
        SEQ_FINISH,
        SEQ_OUT
    } seq_state_t;

endpackage

// ===== design/mcspg_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
// Stand-alone; no package dependency.
module mcspg_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd_en,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mcspg_tick.sv =====
// Per-channel tick update: frame-start latch, hold check, output level, phase advance.
// Depends on mcspg_pkg.
module mcspg_tick (
    input  mcspg_pkg::chan_entry_t entry_cur,
    input  mcspg_pkg::tick_cfg_t   cfg,
    output mcspg_pkg::chan_entry_t entry_next,
    output logic                   level
);
    import mcspg_pkg::*;

    chan_entry_t      frame;
    logic [WIDTH_W:0] phase_inc;

    always_comb begin
        frame = entry_cur;
        // frame start: take a new width or decide whether this frame stays low
        if (entry_cur.phase == '0) begin
            if (entry_cur.req_width != entry_cur.lat_width) begin
                frame.lat_width = entry_cur.req_width;
                frame.unchanged = '0;
                frame.idle      = 1'b0;
            end else begin
                frame.idle = entry_cur.unchanged > cfg.hold_periods;
            end
        end

        level = !frame.idle && (frame.phase < frame.lat_width);

        phase_inc  = {1'b0, frame.phase} + (WIDTH_W+1)'(1);
        entry_next = frame;
        if (phase_inc >= {1'b0, cfg.frame_len}) begin
            entry_next.phase = '0;
            if (frame.unchanged != COUNT_MAX) begin
                entry_next.unchanged = frame.unchanged + WIDTH_W'(1);
            end
        end else begin
            entry_next.phase = phase_inc[WIDTH_W-1:0];
        end
    end

endmodule

// ===== design/multi_channel_servo_pulse_generator_core.sv =====
// Servo pulse generator core. An accepted word passes the sweep, finish and output states.
// A word is taken only in idle, after the last result is loaded; the pace is set by the sweep
// of the channel state memory, one entry per cycle through its single read port.
// Reset (aresetn low, synchronous): registers to defaults, all channels stopped, levels low.
// Entries come back as defaults through per-channel valid bits; there is no clearing pass.
// Depends on mcspg_pkg, mcspg_ram, mcspg_tick.
module multi_channel_servo_pulse_generator_core #(
    parameter int CHANNELS = mcspg_pkg::CHANNELS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [mcspg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcspg_pkg::WIDTH_W-1:0]    cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] channel, [11:3] pin, [27:12] pulse_request, [31:28] zero
    input  logic [mcspg_pkg::S_TDATA_W-1:0]  s_tdata,
    // [2:0] mode
    input  logic [mcspg_pkg::MODE_W-1:0]     s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] pin_levels, [10:8] status, [13:11] channel_out, [15:14] zero
    output logic [mcspg_pkg::M_TDATA_W-1:0]  m_tdata
);
    import mcspg_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    seq_state_t state_reg, state_next;
    logic [CH_W-1:0] cnt_reg, cnt_next;

    logic [WIDTH_W-1:0] frame_len_reg, min_pulse_reg, max_pulse_reg, hold_reg;

    logic [MODE_W-1:0]     mode_reg;
    logic [CH_FIELD_W-1:0] ch_reg;
    logic [PIN_W-1:0]      pin_reg;
    logic [WIDTH_W-1:0]    req_reg;

    logic [CHANNELS-1:0] running_reg, running_next;
    logic [CHANNELS-1:0] valid_reg, valid_next;
    logic [CHANNELS-1:0] levels_reg, levels_next;

    logic            found_reg, found_next;
    logic [CH_W-1:0] found_idx_reg, found_idx_next;

    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [CH_FIELD_W-1:0] chan_out_reg, chan_out_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic            s_accept;
    logic            ch_in_range;
    logic [CH_W-1:0] ch_idx;
    logic [WIDTH_W-1:0] clamp_width;
    logic            clamp_hit;
    logic            sweep_last;
    logic            pin_hit;
    logic            free_found;
    logic [CH_W-1:0] free_idx;

    logic             ram_we, ram_rd_en;
    logic [CH_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    chan_entry_t      wr_entry;
    chan_entry_t      entry_cur;
    chan_entry_t      tick_entry;
    logic             tick_level;
    tick_cfg_t        tick_cfg;

    assign s_tready = (state_reg == SEQ_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign ch_in_range = int'(ch_reg) < CHANNELS;
    assign ch_idx      = ch_reg[CH_W-1:0];
    assign sweep_last  = (cnt_reg == CH_W'(CHANNELS - 1));

    // max is checked first, also when the limits cross: above max gives max, else below min gives min
    always_comb begin
        clamp_width = req_reg;
        clamp_hit   = 1'b0;
        if (req_reg > max_pulse_reg) begin
            clamp_width = max_pulse_reg;
            clamp_hit   = 1'b1;
        end else if (req_reg < min_pulse_reg) begin
            clamp_width = min_pulse_reg;
            clamp_hit   = 1'b1;
        end
    end

    // lowest stopped channel
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!running_reg[i]) begin
                free_found = 1'b1;
                free_idx   = CH_W'(i);
            end
        end
    end

    assign entry_cur = valid_reg[cnt_reg] ? chan_entry_t'(ram_rdata) : ENTRY_RESET;
    assign pin_hit   = running_reg[cnt_reg] && (entry_cur.pin == pin_reg);

    assign tick_cfg.frame_len    = frame_len_reg;
    assign tick_cfg.hold_periods = hold_reg;

    mcspg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .rd_en (ram_rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mcspg_tick u_tick (
        .entry_cur  (entry_cur),
        .cfg        (tick_cfg),
        .entry_next (tick_entry),
        .level      (tick_level)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (s_tvalid) begin
                    state_next = SEQ_SWEEP;
                end
            end
            SEQ_SWEEP: begin
                if (sweep_last) begin
                    state_next = SEQ_FINISH;
                end
            end
            SEQ_FINISH: begin
                state_next = SEQ_OUT;
            end
            SEQ_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = SEQ_IDLE;
                end
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        cnt_next       = cnt_reg;
        running_next   = running_reg;
        valid_next     = valid_reg;
        levels_next    = levels_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        status_next    = status_reg;
        chan_out_next  = chan_out_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg;
        wr_entry       = entry_cur;
        ram_rd_en      = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            SEQ_IDLE: begin
                ram_rd_en  = s_tvalid;
                cnt_next   = '0;
                found_next = 1'b0;
            end
            SEQ_SWEEP: begin
                // entry cnt is written while entry cnt+1 is read: never the same address
                if (!sweep_last) begin
                    ram_rd_en = 1'b1;
                    ram_raddr = cnt_reg + CH_W'(1);
                end
                cnt_next = cnt_reg + CH_W'(1);
                unique case (mode_reg)
                    MODE_TICK: begin
                        if (running_reg[cnt_reg]) begin
                            ram_we               = 1'b1;
                            wr_entry             = tick_entry;
                            valid_next[cnt_reg]  = 1'b1;
                            levels_next[cnt_reg] = tick_level;
                        end
                    end
                    MODE_SET_WIDTH: begin
                        if (ch_in_range && (ch_idx == cnt_reg)) begin
                            ram_we              = 1'b1;
                            wr_entry.req_width  = clamp_width;
                            valid_next[cnt_reg] = 1'b1;
                        end
                    end
                    MODE_START, MODE_STOP_PIN: begin
                        if (!found_reg && pin_hit) begin
                            found_next     = 1'b1;
                            found_idx_next = cnt_reg;
                        end
                    end
                    default: ;
                endcase
            end
            SEQ_FINISH: begin
                status_next   = ST_OK;
                chan_out_next = '0;
                unique case (mode_reg)
                    MODE_SET_WIDTH: begin
                        if (!ch_in_range) begin
                            status_next = ST_BAD_CHANNEL;
                        end else if (clamp_hit) begin
                            status_next = ST_CLAMPED;
                        end
                    end
                    MODE_START: begin
                        if (found_reg) begin
                            status_next   = ST_PIN_IN_USE;
                            chan_out_next = CH_FIELD_W'(found_idx_reg);
                        end else if (!free_found) begin
                            status_next = ST_NO_FREE;
                        end else begin
                            ram_we                 = 1'b1;
                            ram_waddr              = free_idx;
                            wr_entry               = ENTRY_RESET;
                            wr_entry.pin           = pin_reg;
                            valid_next[free_idx]   = 1'b1;
                            running_next[free_idx] = 1'b1;
                            levels_next[free_idx]  = 1'b0;
                            chan_out_next          = CH_FIELD_W'(free_idx);
                        end
                    end
                    MODE_STOP_CH: begin
                        if (!ch_in_range) begin
                            status_next = ST_BAD_CHANNEL;
                        end else if (!running_reg[ch_idx]) begin
                            status_next = ST_NOT_RUNNING;
                        end else begin
                            // width is reset at the next start, so only the run bit matters
                            running_next[ch_idx] = 1'b0;
                            levels_next[ch_idx]  = 1'b0;
                        end
                    end
                    MODE_STOP_PIN: begin
                        if (found_reg) begin
                            running_next[found_idx_reg] = 1'b0;
                            levels_next[found_idx_reg]  = 1'b0;
                            chan_out_next               = CH_FIELD_W'(found_idx_reg);
                        end else begin
                            status_next = ST_PIN_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
            SEQ_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({chan_out_reg, status_reg,
                                                LEVELS_W'(levels_reg)});
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SEQ_IDLE;
            cnt_reg       <= '0;
            running_reg   <= '0;
            valid_reg     <= '0;
            levels_reg    <= '0;
            found_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            frame_len_reg <= FRAME_LEN_RST;
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            hold_reg      <= HOLD_RST;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            running_reg  <= running_next;
            valid_reg    <= valid_next;
            levels_reg   <= levels_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_FRAME_LEN: frame_len_reg <= cfg_wdata;
                    CFG_MIN_PULSE: min_pulse_reg <= cfg_wdata;
                    CFG_MAX_PULSE: max_pulse_reg <= cfg_wdata;
                    CFG_HOLD:      hold_reg      <= cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= s_tuser;
            ch_reg   <= s_tdata[2:0];
            pin_reg  <= s_tdata[11:3];
            req_reg  <= s_tdata[27:12];
        end
        found_idx_reg <= found_idx_next;
        status_reg    <= status_next;
        chan_out_reg  <= chan_out_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // a running channel always has a written state entry
    a_run_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg & ~valid_reg) == '0)
        else $error("running channel without a written state entry");

    // only running channels drive high
    a_level_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (levels_reg & ~running_reg) == '0)
        else $error("stopped channel drives high");

    a_no_rw_collide: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_rd_en) |-> (ram_waddr != ram_raddr))
        else $error("state memory read and write hit the same entry");

    // the result is loaded only once the sweep of this word is done
    a_load_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == SEQ_OUT))
        else $error("result word loaded outside the output state");

endmodule

// ===== verif/tb_multi_channel_servo_pulse_generator_core.sv =====
// Self-checking testbench for multi_channel_servo_pulse_generator_core.
// Runs a directed table, then random words under several register settings, and checks every
// result word against its typed table row or a behavioral servo model. Depends on mcspg_pkg, the core RTL.
`timescale 1ns / 1ps

module tb_multi_channel_servo_pulse_generator_core;
    import mcspg_pkg::*;

    localparam int NCH = CHANNELS_DEF;
    localparam int LATENCY = NCH + 3;

    // modes the block ignores
    localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [LEVELS_W-1:0]   levels;
        logic [STATUS_W-1:0]   status;
        logic [CH_FIELD_W-1:0] chan;
    } servo_res_t;

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [CH_FIELD_W-1:0] ch;
        logic [PIN_W-1:0]      pin;
        logic [WIDTH_W-1:0]    req;
        logic                  known;
        servo_res_t            res;
    } dir_row_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] frame;
        logic [WIDTH_W-1:0] min_w;
        logic [WIDTH_W-1:0] max_w;
        logic [WIDTH_W-1:0] hold;
        logic [WIDTH_W-1:0] n_words;
    } cfg_phase_t;

    localparam int N_DIR = 25;
    // known = 1: typed result is the expectation; otherwise the model decides
    localparam dir_row_t DIR_TABLE [N_DIR] = '{
        '{MODE_TICK,      3'd0, 9'd0,   16'd0,     1'b1, '{8'h00, ST_OK,            3'd0}},
        '{MODE_STOP_CH,   3'd3, 9'd0,   16'd0,     1'b1, '{8'h00, ST_NOT_RUNNING,   3'd0}},
        '{MODE_STOP_PIN,  3'd0, 9'd511, 16'd0,     1'b1, '{8'h00, ST_PIN_NOT_FOUND, 3'd0}},
        '{MODE_SET_WIDTH, 3'd0, 9'd0,   16'd0,     1'b1, '{8'h00, ST_CLAMPED,       3'd0}},
        '{MODE_SET_WIDTH, 3'd1, 9'd0,   16'hFFFF,  1'b1, '{8'h00, ST_CLAMPED,       3'd0}},
        '{MODE_SET_WIDTH, 3'd7, 9'd0,   16'd500,   1'b1, '{8'h00, ST_OK,            3'd0}},
        '{MODE_SET_WIDTH, 3'd6, 9'd0,   16'd2500,  1'b1, '{8'h00, ST_OK,            3'd0}},
        '{MODE_RSVD_LO,   3'd0, 9'd0,   16'd0,     1'b1, '{8'h00, ST_OK,            3'd0}},
        '{MODE_RSVD_HI,   3'd7, 9'd511, 16'hFFFF,  1'b1, '{8'h00, ST_OK,            3'd0}},
        '{MODE_START,     3'd0, 9'd0,   16'd0,     1'b1, '{8'h00, ST_OK,            3'd0}},
        '{MODE_START,     3'd0, 9'd511, 16'd0,     1'b1, '{8'h00, ST_OK,            3'd1}},
        '{MODE_START,     3'd0, 9'd511, 16'd0,     1'b1, '{8'h00, ST_PIN_IN_USE,    3'd1}},
        '{MODE_START,     3'd0, 9'd1,   16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_START,     3'd0, 9'd2,   16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_START,     3'd0, 9'd3,   16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_START,     3'd0, 9'd4,   16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_START,     3'd0, 9'd5,   16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_START,     3'd0, 9'd6,   16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_START,     3'd0, 9'd300, 16'd0,     1'b1, '{8'h00, ST_NO_FREE,       3'd0}},
        '{MODE_TICK,      3'd0, 9'd0,   16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_SET_WIDTH, 3'd2, 9'd0,   16'd700,   1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_STOP_PIN,  3'd0, 9'd511, 16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_STOP_CH,   3'd1, 9'd0,   16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_STOP_CH,   3'd0, 9'd0,   16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}},
        '{MODE_TICK,      3'd0, 9'd0,   16'd0,     1'b0, '{8'h00, ST_OK,            3'd0}}
    };

    // register settings per random phase; frame 0 and shrinking frames wrap the phase early
    localparam int N_PHASES = 8;
    localparam cfg_phase_t PHASES [N_PHASES] = '{
        '{16'd20000, 16'd500,   16'd2500,  16'd50,    16'd100},
        '{16'd10,    16'd2,     16'd7,     16'd2,     16'd160},
        '{16'd1,     16'd0,     16'hFFFF,  16'd0,     16'd120},
        '{16'd6,     16'd5,     16'd3,     16'hFFFF,  16'd120},
        '{16'd0,     16'd0,     16'd0,     16'd1,     16'd60},
        '{16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'd80},
        '{16'd16,    16'd1,     16'd20,    16'd3,     16'd200},
        '{16'd5,     16'd1,     16'd9,     16'd1,     16'd100}
    };

    localparam logic [PIN_W-1:0] PIN_POOL [8] = '{
        9'd0, 9'd511, 9'd1, 9'd256, 9'd85, 9'd170, 9'd300, 9'd7
    };

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [WIDTH_W-1:0]      cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic [MODE_W-1:0]       s_tuser;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;

    multi_channel_servo_pulse_generator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // servo model state
    logic [WIDTH_W-1:0]  frame_len_r, min_pulse_r, max_pulse_r, hold_r;
    logic                ch_run   [NCH];
    logic [PIN_W-1:0]    ch_pin   [NCH];
    logic [WIDTH_W-1:0]  ch_req   [NCH];
    logic [WIDTH_W-1:0]  ch_lat   [NCH];
    logic [WIDTH_W-1:0]  ch_phase [NCH];
    logic [WIDTH_W-1:0]  ch_same  [NCH];
    logic                ch_idle  [NCH];
    logic [LEVELS_W-1:0] levels_r;

    servo_res_t pending_q [$];
    int         errors = 0;
    int         burst_left = 0;
    logic [9:0] rx_cyc = '0;

    task automatic servo_model_reset();
        frame_len_r = FRAME_LEN_RST;
        min_pulse_r = MIN_PULSE_RST;
        max_pulse_r = MAX_PULSE_RST;
        hold_r      = HOLD_RST;
        levels_r    = '0;
        for (int c = 0; c < NCH; c++) begin
            ch_run[c]   = 1'b0;
            ch_pin[c]   = '0;
            ch_req[c]   = DEFAULT_WIDTH;
            ch_lat[c]   = '0;
            ch_phase[c] = '0;
            ch_same[c]  = '0;
            ch_idle[c]  = 1'b0;
        end
    endtask

    task automatic servo_stop(input int c);
        ch_run[c]   = 1'b0;
        ch_req[c]   = DEFAULT_WIDTH;
        levels_r[c] = 1'b0;
    endtask

    // advances the model by one word and returns the result it produces
    task automatic servo_predict(input logic [MODE_W-1:0] mode, input logic [CH_FIELD_W-1:0] ch,
                                 input logic [PIN_W-1:0] pin, input logic [WIDTH_W-1:0] req,
                                 output servo_res_t res);
        int   hit;
        int   free_ch;
        logic [WIDTH_W-1:0] w;
        res.status = ST_OK;
        res.chan   = '0;
        hit = -1;
        for (int c = NCH - 1; c >= 0; c--)
            if (ch_run[c] && ch_pin[c] == pin)
                hit = c;
        case (mode)
            MODE_TICK: begin
                for (int c = 0; c < NCH; c++) begin
                    if (!ch_run[c]) begin
                        levels_r[c] = 1'b0;
                    end else begin
                        if (ch_phase[c] == '0) begin
                            if (ch_req[c] != ch_lat[c]) begin
                                ch_lat[c]  = ch_req[c];
                                ch_same[c] = '0;
                                ch_idle[c] = 1'b0;
                            end else begin
                                ch_idle[c] = ch_same[c] > hold_r;
                            end
                        end
                        levels_r[c] = !ch_idle[c] && ch_phase[c] < ch_lat[c];
                        if ({1'b0, ch_phase[c]} + 17'd1 >= {1'b0, frame_len_r}) begin
                            ch_phase[c] = '0;
                            if (ch_same[c] != COUNT_MAX)
                                ch_same[c] = ch_same[c] + 1'b1;
                        end else begin
                            ch_phase[c] = ch_phase[c] + 1'b1;
                        end
                    end
                end
            end
            MODE_SET_WIDTH: begin
                if (int'(ch) >= NCH) begin
                    res.status = ST_BAD_CHANNEL;
                end else begin
                    w = req;
                    if (req > max_pulse_r) begin
                        w = max_pulse_r;
                        res.status = ST_CLAMPED;
                    end else if (req < min_pulse_r) begin
                        w = min_pulse_r;
                        res.status = ST_CLAMPED;
                    end
                    ch_req[ch] = w;
                end
            end
            MODE_START: begin
                free_ch = -1;
                for (int c = NCH - 1; c >= 0; c--)
                    if (!ch_run[c])
                        free_ch = c;
                if (hit >= 0) begin
                    res.status = ST_PIN_IN_USE;
                    res.chan   = CH_FIELD_W'(hit);
                end else if (free_ch < 0) begin
                    res.status = ST_NO_FREE;
                end else begin
                    ch_run[free_ch]   = 1'b1;
                    ch_pin[free_ch]   = pin;
                    ch_req[free_ch]   = DEFAULT_WIDTH;
                    ch_lat[free_ch]   = '0;
                    ch_phase[free_ch] = '0;
                    ch_same[free_ch]  = '0;
                    ch_idle[free_ch]  = 1'b0;
                    levels_r[free_ch] = 1'b0;
                    res.chan = CH_FIELD_W'(free_ch);
                end
            end
            MODE_STOP_CH: begin
                if (int'(ch) >= NCH)
                    res.status = ST_BAD_CHANNEL;
                else if (!ch_run[ch])
                    res.status = ST_NOT_RUNNING;
                else
                    servo_stop(ch);
            end
            MODE_STOP_PIN: begin
                if (hit < 0) begin
                    res.status = ST_PIN_NOT_FOUND;
                end else begin
                    servo_stop(hit);
                    res.chan = CH_FIELD_W'(hit);
                end
            end
            default: ;
        endcase
        res.levels = levels_r;
    endtask

    // sends one word in bursts with random gaps; the model runs at acceptance
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [CH_FIELD_W-1:0] ch,
                             input logic [PIN_W-1:0] pin, input logic [WIDTH_W-1:0] req,
                             input logic known, input servo_res_t typed);
        int         gap;
        servo_res_t model_res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, req, pin, ch};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        servo_predict(mode, ch, pin, req, model_res);
        pending_q.push_back(known ? typed : model_res);
    endtask

    // hold off the sender until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_regs(input cfg_phase_t p);
        logic [WIDTH_W-1:0] vals [4];
        vals = '{p.frame, p.min_w, p.max_w, p.hold};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            case (i[CFG_IDX_W-1:0])
                CFG_FRAME_LEN: frame_len_r = vals[i];
                CFG_MIN_PULSE: min_pulse_r = vals[i];
                CFG_MAX_PULSE: max_pulse_r = vals[i];
                CFG_HOLD:      hold_r      = vals[i];
                default: ;
            endcase
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_word();
        int                    pick;
        int                    lim;
        logic [MODE_W-1:0]     mode;
        logic [CH_FIELD_W-1:0] ch;
        logic [PIN_W-1:0]      pin;
        logic [WIDTH_W-1:0]    req;
        pick = $urandom_range(0, 99);
        if (pick < 50)      mode = MODE_TICK;
        else if (pick < 68) mode = MODE_SET_WIDTH;
        else if (pick < 80) mode = MODE_START;
        else if (pick < 86) mode = MODE_STOP_CH;
        else if (pick < 94) mode = MODE_STOP_PIN;
        else                mode = MODE_W'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
        ch  = CH_FIELD_W'($urandom_range(0, NCH - 1));
        pin = ($urandom_range(0, 4) == 0) ? PIN_W'($urandom_range(0, 511))
                                          : PIN_POOL[$urandom_range(0, 7)];
        // widths mostly near the clamp window so short frames see real pulses
        lim = int'(max_pulse_r) + 4;
        if (lim > 65535)
            lim = 65535;
        case ($urandom_range(0, 9))
            0:       req = '0;
            1:       req = '1;
            2, 3:    req = WIDTH_W'($urandom);
            default: req = WIDTH_W'($urandom_range(0, lim));
        endcase
        send_word(mode, ch, pin, req, 1'b0, '0);
    endtask

    // receiver back-pressure, cycling through its own windows
    always @(posedge aclk) begin
        rx_cyc <= rx_cyc + 1'b1;
        case (rx_cyc[9:7])
            3'd0, 3'd1: m_tready <= 1'b1;
            3'd2:       m_tready <= rx_cyc[0];
            3'd3:       m_tready <= (rx_cyc[1:0] == 2'b11);
            default:    m_tready <= ($urandom_range(0, 2) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, m_tdata);
                errors++;
            end else begin
                if (m_tdata[7:0] !== pending_q[0].levels) begin
                    $display("%0t: pin_levels expected %h actual %h",
                             $realtime, pending_q[0].levels, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[10:8] !== pending_q[0].status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, pending_q[0].status, m_tdata[10:8]);
                    errors++;
                end
                if (m_tdata[13:11] !== pending_q[0].chan) begin
                    $display("%0t: channel_out expected %0d actual %0d",
                             $realtime, pending_q[0].chan, m_tdata[13:11]);
                    errors++;
                end
                void'(pending_q.pop_front());
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        servo_model_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIR; i++)
            send_word(DIR_TABLE[i].mode, DIR_TABLE[i].ch, DIR_TABLE[i].pin, DIR_TABLE[i].req,
                      DIR_TABLE[i].known, DIR_TABLE[i].res);

        // channels keep running across phases, so a shorter frame lands below the phase
        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            write_regs(PHASES[p]);
            for (int n = 0; n < int'(PHASES[p].n_words); n++)
                send_random_word();
        end

        drain();
        repeat (2 * LATENCY) @(posedge aclk);
        if (errors == 0 && pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mcspg_pkg.sv
design/mcspg_ram.sv
design/mcspg_tick.sv
design/multi_channel_servo_pulse_generator_core.sv
verif/tb_multi_channel_servo_pulse_generator_core.sv
